// ----- hw/rtl/sll_pkg.sv -----
// shared types, constants and helper functions of the shell line lexer
`default_nettype none

package sll_pkg;

	// line positions saturate at the longest line
	localparam int MAX_LINE = 4096;
	localparam int POS_W    = $clog2(MAX_LINE + 1);
	localparam int SPAN_W   = 13;

	// results caused by one item, and bundle queue depth
	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// number of candidate results in fixed emission order
	localparam int NCAND = 6;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [SPAN_W-1:0] span_t;

	// event codes
	localparam logic [1:0] EV_CHAR     = 2'd0;
	localparam logic [1:0] EV_WORD_END = 2'd1;
	localparam logic [1:0] EV_OP       = 2'd2;
	localparam logic [1:0] EV_STATUS   = 2'd3;

	// operator kinds
	localparam logic [2:0] OP_LT   = 3'd0;
	localparam logic [2:0] OP_GT   = 3'd1;
	localparam logic [2:0] OP_GTGT = 3'd2;
	localparam logic [2:0] OP_PIPE = 3'd3;
	localparam logic [2:0] OP_OR   = 3'd4;
	localparam logic [2:0] OP_SEMI = 3'd5;
	localparam logic [2:0] OP_AMP  = 3'd6;
	localparam logic [2:0] OP_AND  = 3'd7;

	// held operator codes
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_PIPE = 2'd1;
	localparam logic [1:0] PEND_AMP  = 2'd2;
	localparam logic [1:0] PEND_GT   = 2'd3;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_PIPE   = 8'h7c;
	localparam logic [7:0] CH_TILDE  = 8'h7e;

	// one result item
	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  char_value;
		logic [2:0]  op_kind;
		span_t       span_begin;
		span_t       span_end;
		logic        line_ok;
		logic        open_single;
		logic        open_double;
		logic        quote_error;
	} res_t;

	// all results of one item, packed from slot 0
	typedef struct packed {
		res_t [MAX_RES-1:0] recs;
		logic [CNT_W-1:0]   cnt;
	} bundle_t;

	function automatic pos_t sat_add(input pos_t v, input logic [1:0] k);
		logic [POS_W:0] r;
		r = {1'b0, v} + (POS_W + 1)'(k);
		if (r > (POS_W + 1)'(MAX_LINE))
			return POS_W'(MAX_LINE);
		return r[POS_W-1:0];
	endfunction

	function automatic span_t to_span(input pos_t p);
		return SPAN_W'(p);
	endfunction

	// backslash is dropped before these bytes
	function automatic logic esc_drops(input logic [7:0] c, input logic in_dbl);
		if (in_dbl)
			return c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR ||
			       c == CH_BANG || c == CH_NL;
		return c == CH_SPACE || c == CH_TAB || c == CH_BSLASH || c == CH_SQUOTE ||
		       c == CH_DQUOTE || c == CH_DOLLAR || c == CH_BANG || c == CH_TILDE ||
		       c == CH_PIPE || c == CH_AMP || c == CH_SEMI || c == CH_LT ||
		       c == CH_GT || c == CH_NL;
	endfunction

	function automatic logic [2:0] single_kind(input logic [1:0] p);
		case (p)
			PEND_PIPE: return OP_PIPE;
			PEND_AMP:  return OP_AMP;
			PEND_GT:   return OP_GT;
			default:   return OP_LT;
		endcase
	endfunction

	function automatic logic [2:0] dbl_kind(input logic [1:0] p);
		case (p)
			PEND_PIPE: return OP_OR;
			PEND_AMP:  return OP_AND;
			PEND_GT:   return OP_GTGT;
			default:   return OP_LT;
		endcase
	endfunction

	function automatic logic [7:0] dbl_char(input logic [1:0] p);
		case (p)
			PEND_PIPE: return CH_PIPE;
			PEND_AMP:  return CH_AMP;
			PEND_GT:   return CH_GT;
			default:   return 8'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sll_ifs.sv -----
// handshake channels for line bytes and lexer results
`default_nettype none

interface sll_byte_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_code;

	modport source(output valid, output mode, output char_code, input ready);
	modport sink(input valid, input mode, input char_code, output ready);
endinterface

interface sll_tok_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                event_res;
	logic [7:0]                char_value;
	logic [2:0]                op_kind;
	logic [sll_pkg::SPAN_W-1:0] span_begin;
	logic [sll_pkg::SPAN_W-1:0] span_end;
	logic                      line_ok;
	logic                      open_single;
	logic                      open_double;
	logic                      quote_error;
	logic                      last;

	modport source(output valid, output event_res, output char_value, output op_kind,
		output span_begin, output span_end, output line_ok, output open_single,
		output open_double, output quote_error, output last, input ready);
	modport sink(input valid, input event_res, input char_value, input op_kind,
		input span_begin, input span_end, input line_ok, input open_single,
		input open_double, input quote_error, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/shell_line_lexer.sv -----
// Shell command-line lexer: one byte or end-of-line item per cycle in, result items out.
// Throughput: one item accepted per cycle while the 4-entry bundle queue has room;
// results leave one per cycle while the sink is ready, up to 4 per item, set by the single output port.
// An accepted item's results are written into the queue and then loaded into the back end before the first is valid.
// Reset (arst_n low, asynchronous): line state cleared, queue empty, strict_mode set to 1.
`default_nettype none

module shell_line_lexer (
	input  wire       clk,
	input  wire       arst_n,
	sll_byte_if.sink  byte_ch,
	sll_tok_if.source tok_ch,
	input  wire       cfg_we,
	input  wire       cfg_wdata
);
	import sll_pkg::*;

	logic    q_push, q_room, q_pop, q_nonempty;
	bundle_t q_din, q_dout;

	// classify bytes and update lexer state
	sll_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_room    (q_room),
		.push      (q_push),
		.bundle    (q_din)
	);

	// decoupling queue
	sll_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      (q_din),
		.room     (q_room),
		.pop      (q_pop),
		.dout     (q_dout),
		.nonempty (q_nonempty)
	);

	// serialize result items
	sll_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_dout     (q_dout),
		.q_nonempty (q_nonempty),
		.q_pop      (q_pop),
		.tok_ch     (tok_ch)
	);

	// a pushed bundle fits the slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_din.cnt != '0) && (q_din.cnt <= CNT_W'(MAX_RES)))
		else $error("bundle count out of range");

	// no push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_room)
		else $error("queue overflow");

	// rest of a bundle follows without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		(tok_ch.valid && tok_ch.ready && !tok_ch.last) |=> tok_ch.valid)
		else $error("bundle interrupted");

endmodule

`default_nettype wire

// ----- hw/rtl/sll_front.sv -----
// front end: lexer state update and result bundle for each accepted item
`default_nettype none

module sll_front (
	input  wire              clk,
	input  wire              arst_n,
	sll_byte_if.sink         byte_ch,
	input  wire              cfg_we,
	input  wire              cfg_wdata,
	input  wire              q_room,
	output logic             push,
	output sll_pkg::bundle_t bundle
);
	import sll_pkg::*;

	// lexer state
	pos_t       pos_q, word_first_q, word_after_q, quote_at_q, pend_at_q;
	logic       in_single_q, in_double_q, esc_q, esc_dbl_q;
	logic       word_open_q, word_text_q, comment_q, strict_q;
	logic [1:0] pend_q;

	pos_t       pos_n, word_first_n, word_after_n, quote_at_n, pend_at_n;
	logic       in_single_n, in_double_n, esc_n, esc_dbl_n;
	logic       word_open_n, word_text_n, comment_n;
	logic [1:0] pend_n;

	logic              acc;
	logic [NCAND-1:0]  cand_en;
	res_t [NCAND-1:0]  cand;

	assign byte_ch.ready = q_room;
	assign acc           = byte_ch.valid && byte_ch.ready;

	// next state and candidate results in emission order
	always_comb begin
		logic [7:0] c;
		logic       doubled;
		logic       unq;
		pos_t       nxt;
		c       = byte_ch.char_code;
		doubled = 1'b0;
		unq     = !in_single_q && !in_double_q;
		nxt     = sat_add(pos_q, 2'd1);

		pos_n        = pos_q;
		word_first_n = word_first_q;
		word_after_n = word_after_q;
		quote_at_n   = quote_at_q;
		pend_at_n    = pend_at_q;
		in_single_n  = in_single_q;
		in_double_n  = in_double_q;
		esc_n        = esc_q;
		esc_dbl_n    = esc_dbl_q;
		word_open_n  = word_open_q;
		word_text_n  = word_text_q;
		comment_n    = comment_q;
		pend_n       = pend_q;

		cand_en = '0;
		cand    = '0;
		cand[0].event_res = EV_OP;
		cand[1].event_res = EV_CHAR;
		cand[1].char_value = CH_BSLASH;
		cand[2].event_res = EV_CHAR;
		cand[2].char_value = c;
		cand[3].event_res = EV_WORD_END;
		cand[4].event_res = EV_OP;
		cand[5].event_res = EV_STATUS;

		if (!byte_ch.mode) begin
			if (comment_q) begin
				pos_n = nxt;
			end else begin
				// held operator resolves against this byte
				if (pend_q != PEND_NONE) begin
					cand_en[0]          = 1'b1;
					cand[0].span_begin  = to_span(pend_at_q);
					if (c == dbl_char(pend_q)) begin
						doubled           = 1'b1;
						cand[0].op_kind   = dbl_kind(pend_q);
						cand[0].span_end  = to_span(sat_add(pend_at_q, 2'd2));
					end else begin
						cand[0].op_kind   = single_kind(pend_q);
						cand[0].span_end  = to_span(sat_add(pend_at_q, 2'd1));
					end
					pend_n    = PEND_NONE;
					pend_at_n = '0;
				end
				if (!doubled) begin
					cand[3].span_begin = to_span(word_first_q);
					cand[3].span_end   = to_span(word_after_q);
					if (esc_q) begin
						cand_en[1]   = !esc_drops(c, esc_dbl_q);
						cand_en[2]   = 1'b1;
						word_text_n  = 1'b1;
						word_after_n = nxt;
						esc_n        = 1'b0;
					end else if (c == CH_BSLASH && !in_single_q) begin
						if (!word_open_q) begin
							word_open_n  = 1'b1;
							word_first_n = pos_q;
						end
						word_after_n = nxt;
						esc_n        = 1'b1;
						esc_dbl_n    = in_double_q;
					end else if (c == CH_SQUOTE && !in_double_q) begin
						if (!word_open_q) begin
							word_open_n  = 1'b1;
							word_first_n = pos_q;
						end
						word_after_n = nxt;
						if (!in_single_q)
							quote_at_n = pos_q;
						in_single_n = !in_single_q;
					end else if (c == CH_DQUOTE && !in_single_q) begin
						if (!word_open_q) begin
							word_open_n  = 1'b1;
							word_first_n = pos_q;
						end
						word_after_n = nxt;
						if (!in_double_q)
							quote_at_n = pos_q;
						in_double_n = !in_double_q;
					end else if (unq && (c == CH_SPACE || c == CH_TAB ||
						(c == CH_HASH && !word_text_q) || c == CH_LT || c == CH_SEMI ||
						c == CH_PIPE || c == CH_AMP || c == CH_GT)) begin
						// word boundary, comment start or operator
						cand_en[3]   = word_open_q;
						word_open_n  = 1'b0;
						word_text_n  = 1'b0;
						word_first_n = '0;
						word_after_n = '0;
						if (c == CH_HASH)
							comment_n = 1'b1;
						if (c == CH_LT || c == CH_SEMI) begin
							cand_en[4]         = 1'b1;
							cand[4].op_kind    = (c == CH_LT) ? OP_LT : OP_SEMI;
							cand[4].span_begin = to_span(pos_q);
							cand[4].span_end   = to_span(nxt);
						end else if (c == CH_PIPE) begin
							pend_n    = PEND_PIPE;
							pend_at_n = pos_q;
						end else if (c == CH_AMP) begin
							pend_n    = PEND_AMP;
							pend_at_n = pos_q;
						end else if (c == CH_GT) begin
							pend_n    = PEND_GT;
							pend_at_n = pos_q;
						end
					end else begin
						// ordinary word character
						if (!word_open_q) begin
							word_open_n  = 1'b1;
							word_first_n = pos_q;
						end
						cand_en[2]   = 1'b1;
						word_text_n  = 1'b1;
						word_after_n = nxt;
					end
				end
				pos_n = nxt;
			end
		end else begin
			// end of line: flush held operator and escape, report quotes
			if (pend_q != PEND_NONE) begin
				cand_en[0]         = 1'b1;
				cand[0].op_kind    = single_kind(pend_q);
				cand[0].span_begin = to_span(pend_at_q);
				cand[0].span_end   = to_span(sat_add(pend_at_q, 2'd1));
			end
			if (esc_q) begin
				cand_en[1]   = 1'b1;
				word_after_n = pos_q;
			end
			cand[3].span_begin  = to_span(word_first_q);
			cand[3].span_end    = to_span(word_after_n);
			cand_en[5]          = 1'b1;
			cand[5].open_single = in_single_q;
			cand[5].open_double = in_double_q;
			if (!unq && strict_q) begin
				cand[5].quote_error = 1'b1;
				cand[5].span_begin  = to_span(quote_at_q);
				cand[5].span_end    = to_span(word_after_n);
			end else begin
				cand_en[3]      = word_open_q;
				cand[5].line_ok = unq;
			end
			// line state back to reset
			pos_n        = '0;
			word_first_n = '0;
			word_after_n = '0;
			quote_at_n   = '0;
			pend_at_n    = '0;
			in_single_n  = 1'b0;
			in_double_n  = 1'b0;
			esc_n        = 1'b0;
			esc_dbl_n    = 1'b0;
			word_open_n  = 1'b0;
			word_text_n  = 1'b0;
			comment_n    = 1'b0;
			pend_n       = PEND_NONE;
		end
	end

	// pack enabled candidates from slot 0
	always_comb begin
		logic [CNT_W-1:0] k;
		k           = '0;
		bundle.recs = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cand_en[i]) begin
				if (k < CNT_W'(MAX_RES))
					bundle.recs[k[IDX_W-1:0]] = cand[i];
				k = k + 1'b1;
			end
		end
		bundle.cnt = k;
	end

	assign push = acc && (bundle.cnt != '0);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			word_first_q <= '0;
			word_after_q <= '0;
			quote_at_q   <= '0;
			pend_at_q    <= '0;
			in_single_q  <= 1'b0;
			in_double_q  <= 1'b0;
			esc_q        <= 1'b0;
			esc_dbl_q    <= 1'b0;
			word_open_q  <= 1'b0;
			word_text_q  <= 1'b0;
			comment_q    <= 1'b0;
			pend_q       <= PEND_NONE;
			strict_q     <= 1'b1;
		end else begin
			if (acc) begin
				pos_q        <= pos_n;
				word_first_q <= word_first_n;
				word_after_q <= word_after_n;
				quote_at_q   <= quote_at_n;
				pend_at_q    <= pend_at_n;
				in_single_q  <= in_single_n;
				in_double_q  <= in_double_n;
				esc_q        <= esc_n;
				esc_dbl_q    <= esc_dbl_n;
				word_open_q  <= word_open_n;
				word_text_q  <= word_text_n;
				comment_q    <= comment_n;
				pend_q       <= pend_n;
			end
			if (cfg_we)
				strict_q <= cfg_wdata;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sll_queue.sv -----
// short queue of result bundles between front and back
`default_nettype none

module sll_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  sll_pkg::bundle_t din,
	output logic             room,
	input  wire              pop,
	output sll_pkg::bundle_t dout,
	output logic             nonempty
);
	import sll_pkg::*;

	bundle_t            slots_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign room     = cnt_q != QCNT_W'(QDEPTH);
	assign nonempty = cnt_q != '0;
	assign dout     = slots_q[rd_ptr_q];

	// bundle storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sll_back.sv -----
// back end: walks each bundle and sends one result item per cycle while the sink is ready
`default_nettype none

module sll_back (
	input  wire              clk,
	input  wire              arst_n,
	input  sll_pkg::bundle_t q_dout,
	input  wire              q_nonempty,
	output logic             q_pop,
	sll_tok_if.source        tok_ch
);
	import sll_pkg::*;

	bundle_t           cur_q;
	logic              cur_valid_q;
	logic [IDX_W-1:0]  idx_q;
	res_t              rec;
	logic              is_last;
	logic              take;

	assign rec     = cur_q.recs[idx_q];
	assign is_last = (CNT_W'(idx_q) + 1'b1) == cur_q.cnt;
	assign take    = tok_ch.valid && tok_ch.ready;
	assign q_pop   = q_nonempty && (!cur_valid_q || (take && is_last));

	// output fields
	assign tok_ch.valid       = cur_valid_q;
	assign tok_ch.event_res   = rec.event_res;
	assign tok_ch.char_value  = rec.char_value;
	assign tok_ch.op_kind     = rec.op_kind;
	assign tok_ch.span_begin  = rec.span_begin;
	assign tok_ch.span_end    = rec.span_end;
	assign tok_ch.line_ok     = rec.line_ok;
	assign tok_ch.open_single = rec.open_single;
	assign tok_ch.open_double = rec.open_double;
	assign tok_ch.quote_error = rec.quote_error;
	assign tok_ch.last        = is_last;

	// current bundle payload
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_dout;
	end

	// bundle valid and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (take && is_last) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- dv/shell_line_lexer_tb.sv -----
// testbench of the shell line lexer: directed and random command lines checked against a predictor
module shell_line_lexer_tb;
	import sll_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int ITEMS = 370;
	localparam logic [7:0] CH_LOW_A = "a";
	localparam logic [7:0] CH_LOW_Z = "z";

	// one result item with its end-of-item mark
	typedef struct packed {
		res_t rec;
		logic last;
	} tok_t;

	// lexer state tracking and the tokens each accepted item is due to produce
	class lex_scoreboard;
		bit strict;
		int pos, wfirst, wafter, qat, pend_at;
		bit in_sq, in_dq, esc, esc_dq, wopen, wtext, skip;
		logic [1:0] pend;
		tok_t tokens_due[$];
		int errors;

		function new();
			strict = 1;
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			pos = 0;
			in_sq = 0;
			in_dq = 0;
			esc = 0;
			esc_dq = 0;
			wopen = 0;
			wtext = 0;
			wfirst = 0;
			wafter = 0;
			qat = 0;
			pend = PEND_NONE;
			pend_at = 0;
			skip = 0;
		endfunction

		function int sat(int v, int k);
			return (v + k > MAX_LINE) ? MAX_LINE : v + k;
		endfunction

		function void put(logic [1:0] ev, logic [7:0] ch, logic [2:0] op, int s, int e,
				bit ok, bit os, bit od, bit qe);
			tok_t t;
			t = '0;
			t.rec.event_res = ev;
			t.rec.char_value = ch;
			t.rec.op_kind = op;
			t.rec.span_begin = span_t'(s);
			t.rec.span_end = span_t'(e);
			t.rec.line_ok = ok;
			t.rec.open_single = os;
			t.rec.open_double = od;
			t.rec.quote_error = qe;
			tokens_due.insert(tokens_due.size(), t);
		endfunction

		function void put_char(logic [7:0] ch);
			put(EV_CHAR, ch, '0, 0, 0, 0, 0, 0, 0);
			wtext = 1;
		endfunction

		function void open_word(int p);
			if (!wopen) begin
				wopen = 1;
				wfirst = p;
			end
		endfunction

		function void end_word();
			if (wopen) begin
				put(EV_WORD_END, '0, '0, wfirst, wafter, 0, 0, 0, 0);
				wopen = 0;
				wtext = 0;
				wfirst = 0;
				wafter = 0;
			end
		endfunction

		// bytes before which a backslash disappears
		function bit drops(logic [7:0] c, bit dq);
			if (dq)
				return c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_BANG ||
					c == CH_NL;
			case (c)
				CH_SPACE, CH_TAB, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_DOLLAR, CH_BANG,
				CH_TILDE, CH_PIPE, CH_AMP, CH_SEMI, CH_LT, CH_GT, CH_NL: return 1;
				default: return 0;
			endcase
		endfunction

		// held operator turned out not to be doubled
		function void flush_single();
			logic [2:0] k;
			case (pend)
				PEND_PIPE: k = OP_PIPE;
				PEND_AMP:  k = OP_AMP;
				default:   k = OP_GT;
			endcase
			put(EV_OP, '0, k, pend_at, sat(pend_at, 1), 0, 0, 0, 0);
			pend = PEND_NONE;
			pend_at = 0;
		endfunction

		function void take_byte(logic [7:0] c);
			int p, nx;
			bit unq;
			p = pos;
			nx = sat(pos, 1);
			// escaped byte
			if (esc) begin
				if (!drops(c, esc_dq))
					put_char(CH_BSLASH);
				put_char(c);
				wafter = nx;
				esc = 0;
				return;
			end
			if (c == CH_BSLASH && !in_sq) begin
				open_word(p);
				wafter = nx;
				esc = 1;
				esc_dq = in_dq;
				return;
			end
			// quote toggles
			if (c == CH_SQUOTE && !in_dq) begin
				open_word(p);
				wafter = nx;
				if (!in_sq)
					qat = p;
				in_sq = !in_sq;
				return;
			end
			if (c == CH_DQUOTE && !in_sq) begin
				open_word(p);
				wafter = nx;
				if (!in_dq)
					qat = p;
				in_dq = !in_dq;
				return;
			end
			unq = !in_sq && !in_dq;
			if (unq && (c == CH_SPACE || c == CH_TAB)) begin
				end_word();
				return;
			end
			if (unq && c == CH_HASH && !wtext) begin
				end_word();
				skip = 1;
				return;
			end
			// operators
			if (unq && (c == CH_LT || c == CH_SEMI)) begin
				end_word();
				put(EV_OP, '0, (c == CH_LT) ? OP_LT : OP_SEMI, p, nx, 0, 0, 0, 0);
				return;
			end
			if (unq && (c == CH_PIPE || c == CH_AMP || c == CH_GT)) begin
				end_word();
				pend = (c == CH_PIPE) ? PEND_PIPE : ((c == CH_AMP) ? PEND_AMP : PEND_GT);
				pend_at = p;
				return;
			end
			open_word(p);
			put_char(c);
			wafter = nx;
		endfunction

		function void note_item(bit m, logic [7:0] c);
			int first;
			bit s, d;
			logic [7:0] twin;
			logic [2:0] dk;
			tok_t t;
			first = tokens_due.size();
			if (!m) begin
				// comment bytes only move the position
				if (skip) begin
					pos = sat(pos, 1);
					return;
				end
				if (pend != PEND_NONE) begin
					case (pend)
						PEND_PIPE: begin twin = CH_PIPE; dk = OP_OR; end
						PEND_AMP:  begin twin = CH_AMP; dk = OP_AND; end
						default:   begin twin = CH_GT; dk = OP_GTGT; end
					endcase
					if (c == twin) begin
						put(EV_OP, '0, dk, pend_at, sat(pend_at, 2), 0, 0, 0, 0);
						pend = PEND_NONE;
						pend_at = 0;
					end else begin
						flush_single();
						take_byte(c);
					end
				end else begin
					take_byte(c);
				end
				pos = sat(pos, 1);
			end else begin
				// end of line
				s = in_sq;
				d = in_dq;
				if (pend != PEND_NONE)
					flush_single();
				if (esc) begin
					put_char(CH_BSLASH);
					wafter = pos;
					esc = 0;
				end
				if (s || d) begin
					if (strict) begin
						put(EV_STATUS, '0, '0, qat, wafter, 0, s, d, 1);
					end else begin
						end_word();
						put(EV_STATUS, '0, '0, 0, 0, 0, s, d, 0);
					end
				end else begin
					end_word();
					put(EV_STATUS, '0, '0, 0, 0, 1, 0, 0, 0);
				end
				clear_line();
			end
			if (tokens_due.size() > first) begin
				t = tokens_due.pop_back();
				t.last = 1;
				tokens_due.insert(tokens_due.size(), t);
			end
		endfunction

		function string show(tok_t t);
			return $sformatf({"ev=%0d ch=%02h op=%0d span=%0d..%0d ",
				"ok=%0b sq=%0b dq=%0b qe=%0b last=%0b"},
				t.rec.event_res, t.rec.char_value, t.rec.op_kind, t.rec.span_begin,
				t.rec.span_end, t.rec.line_ok, t.rec.open_single, t.rec.open_double,
				t.rec.quote_error, t.last);
		endfunction

		function void check_tok(tok_t got);
			tok_t want;
			if (tokens_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %s", $time, show(got));
				return;
			end
			want = tokens_due.pop_front();
			if (want != got) begin
				errors++;
				$display("%0t: result mismatch, expected %s, got %s", $time, show(want),
					show(got));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	sll_byte_if byte_if();
	sll_tok_if tok_if();

	lex_scoreboard sb = new();
	logic [7:0] line_bytes[$];
	bit gaps_on = 1;
	int burst_left = 0;
	int items_sent = 0;
	bit long_hold_req = 0;

	shell_line_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_if),
		.tok_ch(tok_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// result side: check every accepted item, stall on a shifting ratio
	initial begin
		tok_t got;
		int ratio, hold, tick;
		tok_if.ready = 0;
		ratio = 0;
		hold = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (arst_n && tok_if.valid && tok_if.ready) begin
				got.rec.event_res = tok_if.event_res;
				got.rec.char_value = tok_if.char_value;
				got.rec.op_kind = tok_if.op_kind;
				got.rec.span_begin = tok_if.span_begin;
				got.rec.span_end = tok_if.span_end;
				got.rec.line_ok = tok_if.line_ok;
				got.rec.open_single = tok_if.open_single;
				got.rec.open_double = tok_if.open_double;
				got.rec.quote_error = tok_if.quote_error;
				got.last = tok_if.last;
				sb.check_tok(got);
			end
			if (long_hold_req) begin
				hold = 80;
				long_hold_req = 0;
			end
			if (tick % 50 == 0) begin
				case ($urandom_range(4))
					0, 1: ratio = 0;
					2: ratio = 30;
					3: ratio = 60;
					default: ratio = 90;
				endcase
			end
			tick++;
			if (hold > 0) begin
				hold--;
				tok_if.ready <= 0;
			end else begin
				tok_if.ready <= ($urandom_range(99) >= ratio);
			end
		end
	end

	task automatic pause(input int n);
		byte_if.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// offer one item until taken, then maybe open a gap
	task automatic send_item(input bit m, input logic [7:0] c);
		byte_if.valid <= 1;
		byte_if.mode <= m;
		byte_if.char_code <= c;
		do @(posedge clk); while (!byte_if.ready);
		sb.note_item(m, c);
		items_sent++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(24, 1);
				pause($urandom_range(6, 1));
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(0, s[i]);
	endtask

	task automatic end_line();
		send_item(1, 8'($urandom()));
	endtask

	// drain: all tokens in, then room for an item still in flight
	task automatic settle();
		pause(1);
		while (sb.tokens_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_strict(input bit v);
		settle();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.strict = v;
	endtask

	function automatic void add_byte(input logic [7:0] b);
		line_bytes.insert(line_bytes.size(), b);
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(15))
			0: return CH_TAB;
			1: return CH_NL;
			2: return CH_SPACE;
			3: return CH_BANG;
			4: return CH_DQUOTE;
			5: return CH_HASH;
			6: return CH_DOLLAR;
			7: return CH_AMP;
			8: return CH_SQUOTE;
			9: return CH_SEMI;
			10: return CH_LT;
			11: return CH_GT;
			12: return CH_BSLASH;
			13: return CH_PIPE;
			14: return CH_TILDE;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] plain_char();
		return 8'($urandom_range(CH_LOW_Z, CH_LOW_A));
	endfunction

	// mostly well-formed lines of words, quotes, escapes and operators; some noise
	task automatic build_line();
		logic [7:0] c;
		line_bytes.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12, 1)) add_byte(8'($urandom()));
			return;
		end
		repeat ($urandom_range(8, 1)) begin
			case ($urandom_range(11))
				0, 1, 2: repeat ($urandom_range(4, 1)) add_byte(plain_char());
				3: begin
					add_byte(CH_BSLASH);
					add_byte(special_char());
				end
				4: begin
					add_byte(CH_SQUOTE);
					repeat ($urandom_range(3)) begin
						c = $urandom_range(1) ? special_char() : plain_char();
						add_byte(c);
					end
					add_byte(CH_SQUOTE);
				end
				5: begin
					add_byte(CH_DQUOTE);
					repeat ($urandom_range(3)) begin
						if ($urandom_range(1))
							add_byte(CH_BSLASH);
						add_byte($urandom_range(1) ? special_char() : plain_char());
					end
					add_byte(CH_DQUOTE);
				end
				6, 7: begin
					case ($urandom_range(4))
						0: c = CH_PIPE;
						1: c = CH_AMP;
						2: c = CH_GT;
						3: c = CH_LT;
						default: c = CH_SEMI;
					endcase
					add_byte(c);
					if ($urandom_range(1))
						add_byte(c);
				end
				8, 9: add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
				10: begin
					add_byte(CH_HASH);
					repeat ($urandom_range(3)) add_byte(special_char());
				end
				default: begin
					// broken: lone quote or trailing backslash
					case ($urandom_range(2))
						0: add_byte(CH_SQUOTE);
						1: add_byte(CH_DQUOTE);
						default: add_byte(CH_BSLASH);
					endcase
				end
			endcase
		end
	endtask

	// stimulus
	initial begin
		int in_phase;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		byte_if.valid = 0;
		byte_if.mode = 0;
		byte_if.char_code = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// every operator, single and doubled, and the top byte value
		write_strict(1);
		send_text("<>>|;&&>||&");
		send_item(0, 8'hff);
		end_line();
		// escapes outside and inside double quotes, empty word, comment
		send_text("\\a\"\\$\" ''#z");
		end_line();
		// trailing backslash in an unmatched double quote, strict
		send_text("\"\\");
		end_line();
		// unmatched single quote with a zero byte, lenient
		write_strict(0);
		send_text("'");
		send_item(0, 8'h00);
		end_line();

		// random lines in phases, the register changing between them
		for (int ph = 0; items_sent < ITEMS; ph++) begin
			gaps_on = ($urandom_range(3) != 0);
			if (ph == 1) begin
				// sink holds off while lines keep coming
				gaps_on = 0;
				long_hold_req = 1;
			end
			in_phase = 0;
			while (in_phase < 60 && items_sent < ITEMS) begin
				build_line();
				foreach (line_bytes[i])
					send_item(0, line_bytes[i]);
				end_line();
				in_phase += line_bytes.size() + 1;
			end
			write_strict((ph == 0) ? 1'b1 : 1'($urandom_range(1)));
		end

		settle();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- shell_line_lexer.f -----
hw/rtl/sll_pkg.sv
hw/rtl/sll_ifs.sv
hw/rtl/sll_front.sv
hw/rtl/sll_queue.sv
hw/rtl/sll_back.sv
hw/rtl/shell_line_lexer.sv
dv/shell_line_lexer_tb.sv
